/* design/pfla_pkg.sv */
package pfla_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W     = 32;
  localparam int CFG_W      = 13;
  localparam int CMP_W      = 32;
  localparam int PAGE_IDX_W = $clog2(MAX_PAGES);
  localparam int COUNT_W    = $clog2(MAX_PAGES + 1);
  localparam int OFFSET_W   = $clog2(PAGE_BYTES);

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE      = 2'd1;
  localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd2;
  localparam logic [1:0] STATUS_ALREADY_FREE = 2'd3;

  localparam logic REG_RESERVED_PAGES = 1'b0;
  localparam logic REG_PAGE_COUNT     = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic [1:0]        status;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_EXEC
  } state_t;

endpackage

/* design/page_free_list_allocator_core.sv */
// Physical page allocator with a FIFO free list held in a 4096 x 12 queue memory and a
// 4096 x 1 allocation map memory. After reset the block walks all MAX_PAGES (4096) map
// entries, marking every page allocated, and accepts no word meanwhile; configuration
// writes are taken throughout. Alloc, free and the no-op mode read the memories as the
// word is taken, then check, write back and register the result once the output is free.
// Init walks the whole map once, rebuilding the map and the queue one entry a cycle.
// Configure reserved_pages and page_count before the init word.
module page_free_list_allocator_core
  import pfla_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [CFG_W-1:0]      reserved_pages;
  logic [CFG_W-1:0]      page_count;
  logic [PAGE_IDX_W-1:0] cnt;
  logic [PAGE_IDX_W-1:0] head, head_next;
  logic [PAGE_IDX_W-1:0] tail, tail_next;
  logic [COUNT_W-1:0]    free_count, free_count_next;
  in_word_t              in_reg;

  logic                  map_mem [MAX_PAGES];
  logic [PAGE_IDX_W-1:0] q_mem   [MAX_PAGES];
  logic                  map_rd;
  logic [PAGE_IDX_W-1:0] q_rd;

  logic                  map_we, map_wdata;
  logic [PAGE_IDX_W-1:0] map_waddr;
  logic                  q_we;
  logic [PAGE_IDX_W-1:0] q_waddr, q_wdata;

  logic                  in_fire, finish, cnt_last, in_list;
  logic [COUNT_W-1:0]    pages, init_count;
  logic [ADDR_W-OFFSET_W-1:0] free_idx;
  logic                  free_oor;
  logic [PAGE_IDX_W-1:0] alloc_idx;
  out_word_t             res;

  assign in_fire  = in_valid && in_ready;
  assign finish   = (state == ST_EXEC) && (!out_valid || out_ready);
  assign cnt_last = (cnt == PAGE_IDX_W'(MAX_PAGES - 1));

  assign pages = (CMP_W'(page_count) > CMP_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES)
                                                          : COUNT_W'(page_count);
  assign init_count = (CMP_W'(pages) > CMP_W'(reserved_pages))
                    ? COUNT_W'(CMP_W'(pages) - CMP_W'(reserved_pages)) : '0;
  assign in_list = (CMP_W'(cnt) >= CMP_W'(reserved_pages)) && (CMP_W'(cnt) < CMP_W'(pages));

  assign free_idx  = in_reg.address[ADDR_W-1:OFFSET_W];
  assign free_oor  = CMP_W'(free_idx) >= CMP_W'(pages);
  assign alloc_idx = (CMP_W'(q_rd) >= CMP_W'(MAX_PAGES)) ? '0 : q_rd;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_next = (in_data.mode == MODE_INIT) ? ST_INIT : ST_EXEC;
      end
      ST_INIT: begin
        if (cnt_last) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (finish) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    map_we          = 1'b0;
    map_waddr       = cnt;
    map_wdata       = 1'b1;
    q_we            = 1'b0;
    q_waddr         = tail;
    q_wdata         = free_idx[PAGE_IDX_W-1:0];
    head_next       = head;
    tail_next       = tail;
    free_count_next = free_count;
    res             = '{page_address: '0, status: STATUS_OK};
    case (state)
      ST_CLEAR: begin
        map_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_INIT: begin
        map_we    = 1'b1;
        map_wdata = !in_list;
        q_we      = in_list;
        q_waddr   = PAGE_IDX_W'(CMP_W'(cnt) - CMP_W'(reserved_pages));
        q_wdata   = cnt;
      end
      ST_EXEC: begin
        if (finish) begin
          case (in_reg.mode)
            MODE_INIT: begin
              head_next       = '0;
              tail_next       = (init_count == COUNT_W'(MAX_PAGES)) ? '0
                                                                    : PAGE_IDX_W'(init_count);
              free_count_next = init_count;
            end
            MODE_ALLOC: begin
              if (free_count == '0) begin
                res.status = STATUS_NO_FREE;
              end else begin
                map_we           = 1'b1;
                map_waddr        = alloc_idx;
                map_wdata        = 1'b1;
                head_next        = (head == PAGE_IDX_W'(MAX_PAGES - 1)) ? '0 : head + 1'b1;
                free_count_next  = free_count - 1'b1;
                res.page_address = ADDR_W'({alloc_idx, {OFFSET_W{1'b0}}});
              end
            end
            MODE_FREE: begin
              if (free_oor) begin
                res.status = STATUS_OUT_OF_RANGE;
              end else if (!map_rd) begin
                res.status = STATUS_ALREADY_FREE;
              end else begin
                map_we          = 1'b1;
                map_waddr       = free_idx[PAGE_IDX_W-1:0];
                map_wdata       = 1'b0;
                q_we            = 1'b1;
                tail_next       = (tail == PAGE_IDX_W'(MAX_PAGES - 1)) ? '0 : tail + 1'b1;
                free_count_next = free_count + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (in_fire) map_rd <= map_mem[PAGE_IDX_W'(in_data.address[ADDR_W-1:OFFSET_W])];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (in_fire) q_rd <= q_mem[head];
  end

  always_ff @(posedge clk) begin
    if (in_fire) in_reg <= in_data;
    if (finish) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      cnt            <= '0;
      head           <= '0;
      tail           <= '0;
      free_count     <= '0;
      out_valid      <= 1'b0;
      reserved_pages <= '0;
      page_count     <= CFG_W'(4096);
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      free_count <= free_count_next;
      if (state == ST_CLEAR || state == ST_INIT) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RESERVED_PAGES: reserved_pages <= cfg_data;
          REG_PAGE_COUNT:     page_count     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(free_count) <= CMP_W'(MAX_PAGES))
    else $error("free count above capacity");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!in_ready && !out_valid))
    else $error("activity during map clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("word accepted while another is in flight");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!map_we && !q_we))
    else $error("memory write while idle");
`endif

endmodule

/* tb/sv/pfla_checker.sv */
module pfla_checker
  import pfla_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_word_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_word_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               outstanding
);

  logic [PAGE_IDX_W-1:0] free_ring [MAX_PAGES];
  logic [PAGE_IDX_W-1:0] ring_head;
  logic [PAGE_IDX_W-1:0] ring_tail;
  logic [COUNT_W-1:0]    free_pages;
  bit                    page_taken [MAX_PAGES];
  logic [CFG_W-1:0]      reserved_pages;
  logic [CFG_W-1:0]      page_count;
  out_word_t             pending_results [$];

  task automatic flag_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  function automatic void queue_page(logic [PAGE_IDX_W-1:0] idx);
    free_ring[ring_tail] = idx;
    ring_tail = ring_tail + 1'b1;
    free_pages = free_pages + 1'b1;
  endfunction

  function automatic out_word_t apply_page_request(in_word_t w);
    out_word_t                    r;
    logic [CFG_W-1:0]             pages;
    logic [ADDR_W-OFFSET_W-1:0]   pg;
    logic [PAGE_IDX_W-1:0]        idx;
    r = '0;
    pages = (page_count > MAX_PAGES) ? CFG_W'(MAX_PAGES) : page_count;
    case (w.mode)
      MODE_INIT: begin
        ring_head = '0;
        ring_tail = '0;
        free_pages = '0;
        for (int i = 0; i < MAX_PAGES; i++) begin
          page_taken[i] = !(i >= reserved_pages && i < pages);
          if (!page_taken[i]) begin
            queue_page(PAGE_IDX_W'(i));
          end
        end
      end
      MODE_ALLOC: begin
        if (free_pages == 0) begin
          r.status = STATUS_NO_FREE;
        end else begin
          idx = free_ring[ring_head];
          ring_head = ring_head + 1'b1;
          free_pages = free_pages - 1'b1;
          page_taken[idx] = 1'b1;
          r.page_address = ADDR_W'(idx) << OFFSET_W;
        end
      end
      MODE_FREE: begin
        pg = w.address[ADDR_W-1:OFFSET_W];
        if (pg >= pages) begin
          r.status = STATUS_OUT_OF_RANGE;
        end else if (!page_taken[pg]) begin
          r.status = STATUS_ALREADY_FREE;
        end else begin
          page_taken[pg] = 1'b0;
          queue_page(pg[PAGE_IDX_W-1:0]);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      reserved_pages = '0;
      page_count = CFG_W'(MAX_PAGES);
      ring_head = '0;
      ring_tail = '0;
      free_pages = '0;
      for (int i = 0; i < MAX_PAGES; i++) begin
        page_taken[i] = 1'b1;
      end
      pending_results.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RESERVED_PAGES) begin
          reserved_pages = cfg_data;
        end else begin
          page_count = cfg_data;
        end
      end
      // pop before push: a result never belongs to the word taken on the same edge
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected word, page_address", out_data.page_address, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.page_address !== want.page_address) begin
            flag_mismatch("page_address", out_data.page_address, want.page_address);
          end
          if (out_data.status !== want.status) begin
            flag_mismatch("status", ADDR_W'(out_data.status), ADDR_W'(want.status));
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(apply_page_request(in_data));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import pfla_pkg::*;

  localparam logic [1:0] MODE_NOP    = 2'd3;
  localparam int         PHASES      = 14;
  localparam int         PHASE_ITEMS = 78;
  localparam int         HOLD_CYCLES = 300;
  localparam int         TIMEOUT     = 2000000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_RESERVED_PAGES;
  logic [CFG_W-1:0] cfg_data  = '0;

  int fail_count;
  int outstanding;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int cur_reserved;
  int cur_pages;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  page_free_list_allocator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pfla_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (fail_count),
    .outstanding (outstanding)
  );

  task automatic send_word(logic [1:0] mode, logic [ADDR_W-1:0] addr);
    int       gap;
    in_word_t w;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    w.mode = mode;
    w.address = addr;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limits(int res, int cnt);
    cfg_we <= 1'b1;
    cfg_index <= REG_RESERVED_PAGES;
    cfg_data <= CFG_W'(res);
    @(posedge clk);
    cfg_index <= REG_PAGE_COUNT;
    cfg_data <= CFG_W'(cnt);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_reserved = res;
    cur_pages = (cnt > MAX_PAGES) ? MAX_PAGES : cnt;
  endtask

  // receiver: random stall per word, two long hold-offs to back up the block
  initial begin
    int wait_left;
    int taken;
    wait_left = 0;
    taken = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_ready && out_valid) begin
          taken++;
          if (taken == 150 || taken == 600) begin
            wait_left = HOLD_CYCLES;
          end else begin
            wait_left = recv_idle ? $urandom_range(0, 12) : 0;
          end
          if (wait_left != 0) begin
            out_ready <= 1'b0;
          end
        end else if (!out_ready) begin
          if (wait_left == 0) begin
            out_ready <= 1'b1;
          end else begin
            wait_left--;
          end
        end
      end
    end
  end

  initial begin
    int                         res;
    int                         cnt;
    int                         allocs;
    int                         window_lo;
    int                         pick;
    logic [ADDR_W-OFFSET_W-1:0] pg;
    logic [OFFSET_W-1:0]        offset;
    logic [ADDR_W-1:0]          addr;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    cur_reserved = 0;
    cur_pages = MAX_PAGES;

    // free before init runs against the reset map
    send_word(MODE_FREE, 32'h0000_5123);
    send_word(MODE_FREE, 32'h0000_5000);
    send_word(MODE_FREE, 32'hFFFF_FFFF);
    send_word(MODE_ALLOC, 32'hFFFF_FFFF);
    send_word(MODE_ALLOC, 32'h0000_0000);
    send_word(MODE_NOP, 32'hFFFF_FFFF);
    send_word(MODE_INIT, 32'hA5A5_5A5A);
    send_word(MODE_ALLOC, 32'h0000_0000);
    send_word(MODE_FREE, 32'h0000_0FFF);
    send_word(MODE_FREE, 32'h0000_0ABC);
    send_word(MODE_FREE, 32'h00FF_F000);
    send_word(MODE_FREE, 32'h0100_0000);
    settle();
    set_limits(16, 40);
    send_word(MODE_INIT, 32'h0000_0000);
    send_word(MODE_FREE, 32'h0000_3000);
    send_word(MODE_FREE, 32'h0002_8000);
    send_word(MODE_FREE, 32'h0002_7FFF);
    send_word(MODE_ALLOC, 32'h0000_0000);
    settle();
    set_limits(50, 20);
    send_word(MODE_INIT, 32'hFFFF_FFFF);
    send_word(MODE_ALLOC, 32'h0000_0000);
    send_word(MODE_FREE, 32'h0001_3000);
    send_word(MODE_ALLOC, 32'h0000_0000);
    settle();
    set_limits(8191, 8191);
    send_word(MODE_INIT, 32'h0000_0000);
    send_word(MODE_FREE, 32'h00FF_F000);
    send_word(MODE_FREE, 32'h0100_0000);
    send_word(MODE_ALLOC, 32'h0000_0000);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin res = 0;    cnt = 4096; end
        1: begin res = 0;    cnt = 1;    end
        2: begin res = 4096; cnt = 4096; end
        3: begin res = 0;    cnt = 0;    end
        4: begin res = 2;    cnt = 8191; end
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            cnt = $urandom_range(0, 8191);
            res = $urandom_range(0, 8191);
          end else begin
            cnt = $urandom_range(1, 64);
            res = $urandom_range(0, 8);
          end
        end
      endcase
      settle();
      set_limits(res, cnt);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      send_word(MODE_INIT, $urandom());
      allocs = 0;
      for (int k = 1; k < PHASE_ITEMS; k++) begin
        window_lo = (cur_reserved < cur_pages) ? cur_reserved : 0;
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
          send_word(MODE_INIT, $urandom());
          allocs = 0;
        end else if (pick < 46) begin
          send_word(MODE_ALLOC, $urandom());
          allocs++;
        end else if (pick < 94) begin
          offset = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            pg = (ADDR_W-OFFSET_W)'(window_lo + $urandom_range(0, allocs + 1));
            addr = {pg, offset};
          end else if (pick < 9) begin
            pg = (ADDR_W-OFFSET_W)'($urandom_range(0, cur_pages + 1));
            addr = {pg, offset};
          end else begin
            addr = $urandom();
          end
          send_word(MODE_FREE, addr);
        end else begin
          send_word(MODE_NOP, $urandom());
        end
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("page_free_list_allocator_core: match");
    end else begin
      $display("page_free_list_allocator_core: mismatch");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("page_free_list_allocator_core: mismatch");
    $finish;
  end

endmodule

/* page_free_list_allocator_core.f */
design/pfla_pkg.sv
design/page_free_list_allocator_core.sv
tb/sv/pfla_checker.sv
tb/sv/tb_top.sv
